// File: rtl/cmrd_pkg.sv
// Shared types and constants for the cone map radius de-duplication unit.
package cmrd_pkg;

  // Field widths fixed by the stream and register formats
  localparam int COORD_W     = 16;
  localparam int COLOUR_W    = 3;
  localparam int THR_W       = 16;
  localparam int STATUS_W    = 2;
  localparam int SLOT_W      = 8;
  localparam int COUNT_OUT_W = 9;
  localparam int SQ_W        = 2 * COORD_W;

  // Stream widths; the tdata widths are byte-padded
  localparam int S_TDATA_W = 2 * COORD_W;
  localparam int S_TUSER_W = COLOUR_W;
  localparam int M_TDATA_W = 24;
  localparam int M_TUSER_W = STATUS_W;

  // Default table depth
  localparam int MAX_ENTRIES_DEFAULT = 256;

  // Register file
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic [APB_ADDR_W-3:0] REG_NEAR_THRESHOLD = 1'b0;
  localparam logic [THR_W-1:0] NEAR_THRESHOLD_RESET = 16'd384;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_ADDED = 2'd0,
    STATUS_NEAR  = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // Control that travels alongside each probe through the distance pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } probe_tag_t;

endpackage

// File: rtl/cone_map_radius_dedup_unit.sv
// Top level of the cone map radius de-duplication unit.
// Each detection on the input stream is checked against every stored landmark, one entry
// per cycle through the single read port of the position memory and a pipelined distance
// compare. The scan ends at once on an empty table and stops early when a near entry is
// found, at the lowest near index; the result is then held until it is transferred. The
// input is not ready until the result has been taken.
// The squared radius is registered from near_threshold, itself registered on a write.
module cone_map_radius_dedup_unit #(
  parameter int MAX_ENTRIES = cmrd_pkg::MAX_ENTRIES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [cmrd_pkg::S_TDATA_W-1:0]    s_tdata,  // [15:0] pos_x, [31:16] pos_y
  input  logic [cmrd_pkg::S_TUSER_W-1:0]    s_tuser,  // [2:0] cone_colour
  // Result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [cmrd_pkg::M_TDATA_W-1:0]    m_tdata,  // [7:0] slot, [16:8] entry_count
  output logic [cmrd_pkg::M_TUSER_W-1:0]    m_tuser,  // [1:0] status
  // Configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cmrd_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [cmrd_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [cmrd_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int WORD_W = 2 * cmrd_pkg::COORD_W + cmrd_pkg::COLOUR_W;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_RESULT = 3'b100
  } state_t;

  state_t state, state_next;

  logic [cmrd_pkg::THR_W-1:0]          near_threshold;
  logic [cmrd_pkg::SQ_W-1:0]           limit;
  logic [CNT_W-1:0]                    count;
  logic signed [cmrd_pkg::COORD_W-1:0] probe_x, probe_y;
  logic [cmrd_pkg::COLOUR_W-1:0]       probe_colour;
  logic [IDX_W-1:0]                    issue_idx;
  logic                                issuing;
  logic                                issue_last;
  cmrd_pkg::probe_tag_t                issue_tag, res_tag;
  logic [IDX_W-1:0]                    res_idx;
  logic                                hit;
  logic                                finish;
  logic                                is_full;
  logic                                do_add;
  logic [WORD_W-1:0]                   rd_word;
  cmrd_pkg::status_t                   res_status;
  logic [cmrd_pkg::SLOT_W-1:0]         res_slot;
  logic [cmrd_pkg::COUNT_OUT_W-1:0]    res_count;
  logic                                s_xfer, m_xfer, cfg_write;

  // Register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[cmrd_pkg::APB_ADDR_W-1:2] == cmrd_pkg::REG_NEAR_THRESHOLD);

  always_comb begin
    if (paddr[cmrd_pkg::APB_ADDR_W-1:2] == cmrd_pkg::REG_NEAR_THRESHOLD) begin
      prdata = cmrd_pkg::APB_DATA_W'(near_threshold);
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      near_threshold <= cmrd_pkg::NEAR_THRESHOLD_RESET;
    end else if (cfg_write) begin
      near_threshold <= pwdata[cmrd_pkg::THR_W-1:0];
    end
  end

  // Hold the squared radius
  always_ff @(posedge clk) begin
    limit <= near_threshold * near_threshold;
  end

  // Handshakes
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_RESULT);
  assign s_xfer   = s_tvalid && s_tready;
  assign m_xfer   = m_tvalid && m_tready;
  assign m_tdata  = cmrd_pkg::M_TDATA_W'({res_count, res_slot});
  assign m_tuser  = res_status;

  // Scan issue: one read a cycle until the last stored entry is requested
  assign issue_last = (CNT_W'(issue_idx) == (count - CNT_W'(1)));
  assign issue_tag  = {(state == S_SCAN) && issuing, issue_last};

  // Scan ends on the first near entry, after the last entry, or at once on an empty table
  assign finish  = (state == S_SCAN)
                   && ((count == '0) || (res_tag.valid && (hit || res_tag.last)));
  assign is_full = (count == CNT_W'(MAX_ENTRIES));
  assign do_add  = finish && !hit && !is_full;

  cmrd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (do_add),
    .waddr (count[IDX_W-1:0]),
    .wdata ({probe_colour, probe_y, probe_x}),
    .raddr (issue_idx),
    .rdata (rd_word)
  );

  cmrd_dist #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk     (clk),
    .rst     (rst),
    .flush   (finish),
    .tag_in  (issue_tag),
    .idx_in  (issue_idx),
    .probe_x (probe_x),
    .probe_y (probe_y),
    .rd_x    (rd_word[cmrd_pkg::COORD_W-1:0]),
    .rd_y    (rd_word[2*cmrd_pkg::COORD_W-1:cmrd_pkg::COORD_W]),
    .limit   (limit),
    .res_tag (res_tag),
    .res_idx (res_idx),
    .hit     (hit)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (s_xfer) state_next = S_SCAN;
      S_SCAN:   if (finish) state_next = S_RESULT;
      S_RESULT: if (m_xfer) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      issuing <= 1'b0;
    end else begin
      state <= state_next;
      if (s_xfer) begin
        issuing <= (count != '0);
      end else if (finish || (issue_tag.valid && issue_last)) begin
        issuing <= 1'b0;
      end
      if (do_add) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // Latch the probe, advance the read address
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      probe_x      <= s_tdata[cmrd_pkg::COORD_W-1:0];
      probe_y      <= s_tdata[2*cmrd_pkg::COORD_W-1:cmrd_pkg::COORD_W];
      probe_colour <= s_tuser[cmrd_pkg::COLOUR_W-1:0];
      issue_idx    <= '0;
    end else if (issue_tag.valid && !issue_last) begin
      issue_idx <= issue_idx + IDX_W'(1);
    end
  end

  // Capture the result at the end of the scan
  always_ff @(posedge clk) begin
    if (finish) begin
      if (hit) begin
        res_status <= cmrd_pkg::STATUS_NEAR;
        res_slot   <= cmrd_pkg::SLOT_W'(res_idx);
        res_count  <= cmrd_pkg::COUNT_OUT_W'(count);
      end else if (is_full) begin
        res_status <= cmrd_pkg::STATUS_FULL;
        res_slot   <= '0;
        res_count  <= cmrd_pkg::COUNT_OUT_W'(count);
      end else begin
        res_status <= cmrd_pkg::STATUS_ADDED;
        res_slot   <= cmrd_pkg::SLOT_W'(count);
        res_count  <= cmrd_pkg::COUNT_OUT_W'(count + CNT_W'(1));
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ENTRIES))
    else $error("stored count beyond table depth");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    do_add |=> (count == $past(count) + CNT_W'(1)))
    else $error("append did not advance the stored count");

  a_results_in_scan: assert property (@(posedge clk) disable iff (rst)
    res_tag.valid |-> (state == S_SCAN))
    else $error("distance result outside a scan");

  a_full_no_write: assert property (@(posedge clk) disable iff (rst)
    is_full |-> !do_add)
    else $error("write into a full table");

  a_near_slot_stored: assert property (@(posedge clk) disable iff (rst)
    (finish && hit) |-> (CNT_W'(res_idx) < count))
    else $error("near entry index beyond stored entries");
`endif

endmodule

// File: rtl/cmrd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module cmrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/cmrd_dist.sv
// Pipelined squared-distance compare shared across all stored entries of a scan.
module cmrd_dist #(
  parameter int IDX_W = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                flush,
  input  cmrd_pkg::probe_tag_t                tag_in,
  input  logic [IDX_W-1:0]                    idx_in,
  input  logic signed [cmrd_pkg::COORD_W-1:0] probe_x,
  input  logic signed [cmrd_pkg::COORD_W-1:0] probe_y,
  input  logic signed [cmrd_pkg::COORD_W-1:0] rd_x,
  input  logic signed [cmrd_pkg::COORD_W-1:0] rd_y,
  input  logic [cmrd_pkg::SQ_W-1:0]           limit,
  output cmrd_pkg::probe_tag_t                res_tag,
  output logic [IDX_W-1:0]                    res_idx,
  output logic                                hit
);

  cmrd_pkg::probe_tag_t tag1, tag2, tag3;
  logic [IDX_W-1:0] idx1, idx2, idx3;
  logic [cmrd_pkg::COORD_W:0] dx, dy;
  logic [cmrd_pkg::COORD_W-1:0] ax, ay;
  logic [cmrd_pkg::SQ_W-1:0] sx, sy;
  logic [cmrd_pkg::SQ_W:0] dsum;

  // Signed coordinate differences against the entry just read
  always_comb begin
    dx = {probe_x[cmrd_pkg::COORD_W-1], probe_x} - {rd_x[cmrd_pkg::COORD_W-1], rd_x};
    dy = {probe_y[cmrd_pkg::COORD_W-1], probe_y} - {rd_y[cmrd_pkg::COORD_W-1], rd_y};
  end

  // Advance the tags; flush kills everything in flight
  always_ff @(posedge clk) begin
    if (rst || flush) begin
      tag1 <= '0;
      tag2 <= '0;
      tag3 <= '0;
    end else begin
      tag1 <= tag_in;
      tag2 <= tag1;
      tag3 <= tag2;
    end
  end

  // Payload stages: read alignment, absolute difference, squares
  always_ff @(posedge clk) begin
    idx1 <= idx_in;
    idx2 <= idx1;
    idx3 <= idx2;
    ax   <= dx[cmrd_pkg::COORD_W] ? cmrd_pkg::COORD_W'(-dx) : dx[cmrd_pkg::COORD_W-1:0];
    ay   <= dy[cmrd_pkg::COORD_W] ? cmrd_pkg::COORD_W'(-dy) : dy[cmrd_pkg::COORD_W-1:0];
    sx   <= ax * ax;
    sy   <= ay * ay;
  end

  // Sum and strict compare against the squared radius
  always_comb begin
    dsum    = {1'b0, sx} + {1'b0, sy};
    hit     = tag3.valid && (dsum < {1'b0, limit});
    res_tag = tag3;
    res_idx = idx3;
  end

endmodule

// File: sim/cone_map_radius_dedup_unit_test.sv
// Self-checking testbench for the cone map radius de-duplication unit.
module cone_map_radius_dedup_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ENTRIES = cmrd_pkg::MAX_ENTRIES_DEFAULT;
  localparam int MAX_CYCLES = 4_000_000;
  localparam int DRAIN_CYCLES = MAX_ENTRIES + 40;
  localparam logic [cmrd_pkg::APB_ADDR_W-3:0] REG_SPARE = 1'b1;
  localparam logic [cmrd_pkg::APB_ADDR_W-1:0] THRESHOLD_ADDR =
    {cmrd_pkg::REG_NEAR_THRESHOLD, 2'b00};
  localparam logic [cmrd_pkg::APB_ADDR_W-1:0] SPARE_ADDR = {REG_SPARE, 2'b00};

  typedef struct packed {
    cmrd_pkg::status_t status;
    logic [cmrd_pkg::SLOT_W-1:0] slot;
    logic [cmrd_pkg::COUNT_OUT_W-1:0] count;
  } map_result_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [cmrd_pkg::S_TDATA_W-1:0] s_tdata;  // [15:0] pos_x, [31:16] pos_y
  logic [cmrd_pkg::S_TUSER_W-1:0] s_tuser;  // [2:0] cone_colour
  logic m_tvalid;
  logic m_tready;
  logic [cmrd_pkg::M_TDATA_W-1:0] m_tdata;  // [7:0] slot, [16:8] entry_count
  logic [cmrd_pkg::M_TUSER_W-1:0] m_tuser;  // [1:0] status
  logic psel;
  logic penable;
  logic pwrite;
  logic [cmrd_pkg::APB_ADDR_W-1:0] paddr;
  logic [cmrd_pkg::APB_DATA_W-1:0] pwdata;
  logic [cmrd_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  // Mirror of the landmark map and its radius register
  logic signed [cmrd_pkg::COORD_W-1:0] map_x[MAX_ENTRIES];
  logic signed [cmrd_pkg::COORD_W-1:0] map_y[MAX_ENTRIES];
  logic [cmrd_pkg::COLOUR_W-1:0] map_colour[MAX_ENTRIES];
  int map_count;
  logic [cmrd_pkg::THR_W-1:0] near_radius;

  map_result_t pending_results[$];
  int errors;
  int cycles;
  bit quiet;
  int stall_left;

  cone_map_radius_dedup_unit #(.MAX_ENTRIES(MAX_ENTRIES)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count cycles and give up well beyond the slowest correct run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > MAX_CYCLES) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Mostly short gaps, now and then a long one, none while quiet
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Classify a detection against the map and append it when it is new
  function automatic map_result_t classify_detection(
    logic signed [cmrd_pkg::COORD_W-1:0] x,
    logic signed [cmrd_pkg::COORD_W-1:0] y,
    logic [cmrd_pkg::COLOUR_W-1:0] colour
  );
    map_result_t r;
    longint radius_sq;
    longint dx;
    longint dy;
    bit hit;
    radius_sq = longint'(near_radius) * longint'(near_radius);
    hit = 1'b0;
    r.status = cmrd_pkg::STATUS_ADDED;
    r.slot = '0;
    for (int i = 0; i < map_count; i++) begin
      dx = longint'(x) - longint'(map_x[i]);
      dy = longint'(y) - longint'(map_y[i]);
      if (dx * dx + dy * dy < radius_sq) begin
        hit = 1'b1;
        r.status = cmrd_pkg::STATUS_NEAR;
        r.slot = cmrd_pkg::SLOT_W'(i);
        break;
      end
    end
    if (!hit) begin
      if (map_count >= MAX_ENTRIES) begin
        r.status = cmrd_pkg::STATUS_FULL;
      end else begin
        map_x[map_count] = x;
        map_y[map_count] = y;
        map_colour[map_count] = colour;
        r.slot = cmrd_pkg::SLOT_W'(map_count);
        map_count++;
      end
    end
    r.count = cmrd_pkg::COUNT_OUT_W'(map_count);
    return r;
  endfunction

  // Offer one detection, wait for its transfer and record the expected result
  task automatic send_detection(input logic [cmrd_pkg::COORD_W-1:0] x,
                                input logic [cmrd_pkg::COORD_W-1:0] y,
                                input logic [cmrd_pkg::COLOUR_W-1:0] colour);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata = {y, x};
    s_tuser = colour;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    pending_results.insert(pending_results.size(), classify_detection(x, y, colour));
    @(negedge clk);
  endtask

  // Either land close to a stored landmark or anywhere on the map
  task automatic send_random_detection(input int near_pct);
    logic [cmrd_pkg::COORD_W-1:0] x;
    logic [cmrd_pkg::COORD_W-1:0] y;
    int k;
    int span;
    int roll;
    if (map_count > 0 && $urandom_range(1, 100) <= near_pct) begin
      k = $urandom_range(0, map_count - 1);
      span = int'(near_radius) + 2;
      x = map_x[k] + cmrd_pkg::COORD_W'(int'($urandom_range(0, 2 * span)) - span);
      y = map_y[k] + cmrd_pkg::COORD_W'(int'($urandom_range(0, 2 * span)) - span);
    end else begin
      x = cmrd_pkg::COORD_W'($urandom_range(0, 65535));
      y = cmrd_pkg::COORD_W'($urandom_range(0, 65535));
      roll = $urandom_range(0, 9);
      if (roll == 0) x = {1'b1, {(cmrd_pkg::COORD_W-1){1'b0}}};
      if (roll == 1) y = {1'b0, {(cmrd_pkg::COORD_W-1){1'b1}}};
    end
    send_detection(x, y, cmrd_pkg::COLOUR_W'($urandom_range(0, 7)));
  endtask

  // Stop offering and hold until every expected result has been transferred
  task automatic drain_results();
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic reg_write(input logic [cmrd_pkg::APB_ADDR_W-1:0] addr,
                           input logic [cmrd_pkg::APB_DATA_W-1:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == THRESHOLD_ADDR) near_radius = value[cmrd_pkg::THR_W-1:0];
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Read the radius register and compare it with the mirror
  task automatic check_radius_register();
    logic [cmrd_pkg::APB_DATA_W-1:0] got;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = THRESHOLD_ADDR;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (got[cmrd_pkg::THR_W-1:0] !== near_radius) begin
      $error("near_threshold: expected %0d, got %0d", near_radius,
             got[cmrd_pkg::THR_W-1:0]);
      errors++;
    end
  endtask

  task automatic set_radius(input logic [cmrd_pkg::THR_W-1:0] value);
    drain_results();
    reg_write(THRESHOLD_ADDR, cmrd_pkg::APB_DATA_W'(value));
    check_radius_register();
  endtask

  // Reset value, and a write to an unmapped address leaving the radius alone
  task automatic test_register_access();
    check_radius_register();
    reg_write(SPARE_ADDR, '1);
    check_radius_register();
  endtask

  // Field extremes, exact duplicates and the boundary of the radius
  task automatic test_directed_extremes();
    send_detection(16'sd0, 16'sd0, 3'd0);
    send_detection(16'sd0, 16'sd0, 3'd7);
    send_detection(16'sd384, 16'sd0, 3'd1);
    send_detection(16'sd383, 16'sd0, 3'd2);
    send_detection(16'h8000, 16'h8000, 3'd3);
    send_detection(16'h7fff, 16'h7fff, 3'd4);
    send_detection(16'h8000, 16'h7fff, 3'd5);
    send_detection(16'h7fff, 16'h8000, 3'd6);
    send_detection(16'h8000 + 16'd383, 16'h8000, 3'd7);
    send_detection(16'h7fff, 16'h7fff, 3'd0);
    send_detection(16'sd1000, -16'sd1000, 3'd5);
    send_detection(-16'sd1000, 16'sd1000, 3'd6);
  endtask

  // Zero radius never matches; radius one matches exact duplicates; maximum matches wide
  task automatic test_radius_extremes();
    set_radius('0);
    send_detection(16'sd0, 16'sd0, 3'd1);
    send_detection(16'sd0, 16'sd0, 3'd2);
    set_radius(16'd1);
    send_detection(16'sd0, 16'sd0, 3'd3);
    send_detection(16'sd1, 16'sd0, 3'd4);
    send_detection(16'sd1, 16'sd1, 3'd5);
    set_radius('1);
    send_detection(16'h8000, 16'h8000, 3'd6);
    send_detection(16'h7fff, 16'h7fff, 3'd7);
    send_detection(16'sd0, 16'h8000, 3'd0);
  endtask

  // Bursts of mixed detections under a range of radii, some without idling
  task automatic test_random_mix();
    logic [cmrd_pkg::THR_W-1:0] radius;
    for (int round = 0; round < 7; round++) begin
      case (round)
        0: radius = cmrd_pkg::NEAR_THRESHOLD_RESET;
        1: radius = cmrd_pkg::THR_W'($urandom_range(2, 1500));
        2: radius = '1;
        3: radius = 16'd1;
        4: radius = cmrd_pkg::THR_W'($urandom_range(1500, 20000));
        5: radius = cmrd_pkg::THR_W'($urandom_range(0, 65535));
        default: radius = cmrd_pkg::NEAR_THRESHOLD_RESET;
      endcase
      set_radius(radius);
      quiet = (round == 2 || round == 5);
      repeat (200) send_random_detection(55);
    end
    quiet = 1'b0;
  endtask

  // Fill the table, then check full, and near taking priority over full
  task automatic test_table_full();
    set_radius('0);
    while (map_count < MAX_ENTRIES) send_random_detection(0);
    repeat (20) send_random_detection(50);
    set_radius(cmrd_pkg::NEAR_THRESHOLD_RESET);
    for (int i = 0; i < 40; i++) begin
      if (i % 4 == 0) begin
        send_detection(map_x[MAX_ENTRIES-1], map_y[MAX_ENTRIES-1],
                       map_colour[MAX_ENTRIES-1]);
      end else begin
        send_random_detection(50);
      end
    end
    set_radius(cmrd_pkg::THR_W'($urandom_range(2, 400)));
    repeat (30) send_random_detection(40);
  endtask

  // Stall the result side at random
  initial begin
    m_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        m_tready = 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Compare each transferred result with the oldest expectation
  always @(posedge clk) begin : check_results
    map_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no detection outstanding: status %0d slot %0d count %0d",
               m_tuser, m_tdata[7:0], m_tdata[16:8]);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser);
          errors++;
        end
        if (m_tdata[7:0] !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, m_tdata[7:0]);
          errors++;
        end
        if (m_tdata[16:8] !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, m_tdata[16:8]);
          errors++;
        end
      end
    end
  end

  initial begin
    errors = 0;
    quiet = 1'b0;
    map_count = 0;
    near_radius = cmrd_pkg::NEAR_THRESHOLD_RESET;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    test_register_access();
    test_directed_extremes();
    test_radius_extremes();
    test_random_mix();
    test_table_full();

    // Let any stray result show up before the verdict
    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
